@@ sv/tdpt_pkg.sv @@
// tdpt_pkg: shared types and constants of the trial division prime test unit
// holds the command and status structs that join the controller and the datapath
// no dependencies
package tdpt_pkg;

    // width of the number_value field on the port
    localparam int NUMBER_WIDTH = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;          // capture a new item and set the first divisor
        logic div_start;     // clear the remainder and start a serial division
        logic div_step;      // one restoring division step
        logic next_divisor;  // advance divisor and its square
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic below_two;     // negative, zero or one
        logic is_two;        // value is exactly two
        logic sq_over;       // divisor squared exceeds the value
        logic div_last;      // the current division step is the last one
        logic rem_zero;      // remainder of the finished division is zero
    } t_dp_status;

endpackage

@@ sv/tdpt_datapath.sv @@
// tdpt_datapath: value, divisor, divisor square and serial remainder registers
// one quotient bit per cycle by restoring division, square kept by adding 2d+1
// depends on tdpt_pkg
module tdpt_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic [tdpt_pkg::NUMBER_WIDTH-1:0] i_number_value,
    input  tdpt_pkg::t_dp_cmd                 i_cmd,
    output tdpt_pkg::t_dp_status              o_status
);
    import tdpt_pkg::*;

    // magnitude bits, divisor bits, square bits, step counter bits
    localparam int NW  = VALUE_WIDTH - 1;
    localparam int DW  = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SW  = VALUE_WIDTH;
    localparam int SCW = $clog2(NW);

    logic [VALUE_WIDTH-1:0] w_value;
    logic                   r_neg;
    logic [NW-1:0]          r_value;
    logic [NW-1:0]          r_shift;
    logic [DW-1:0]          r_div;
    logic [SW-1:0]          r_sq;
    logic [DW-1:0]          r_rem;
    logic [SCW-1:0]         r_step;
    logic [DW:0]            w_trial;
    logic                   w_fits;

    // bring the port value to the configured width
    generate
        if (VALUE_WIDTH <= NUMBER_WIDTH) begin : g_trunc
            assign w_value = i_number_value[VALUE_WIDTH-1:0];
        end else begin : g_sext
            assign w_value = {{(VALUE_WIDTH - NUMBER_WIDTH){i_number_value[NUMBER_WIDTH-1]}},
                              i_number_value};
        end
    endgenerate

    // one restoring step: shift in the next dividend bit and try to subtract
    assign w_trial = {r_rem, r_shift[NW-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    // value and divisor bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg   <= w_value[VALUE_WIDTH-1];
            r_value <= w_value[NW-1:0];
            r_div   <= DW'(2);
            r_sq    <= SW'(4);
        end else if (i_cmd.next_divisor) begin
            r_div <= r_div + DW'(1);
            r_sq  <= r_sq + SW'({r_div, 1'b1});
        end
    end

    // serial remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem   <= '0;
            r_shift <= r_value;
            r_step  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem   <= w_fits ? DW'(w_trial - {1'b0, r_div}) : DW'(w_trial);
            r_shift <= {r_shift[NW-2:0], 1'b0};
            r_step  <= r_step + SCW'(1);
        end
    end

    // status toward the controller
    always_comb begin
        o_status.below_two = r_neg || (r_value < NW'(2));
        o_status.is_two    = !r_neg && (r_value == NW'(2));
        o_status.sq_over   = (r_sq > {1'b0, r_value});
        o_status.div_last  = (r_step == SCW'(NW - 1));
        o_status.rem_zero  = (r_rem == '0);
    end

endmodule

@@ sv/tdpt_ctrl.sv @@
// tdpt_ctrl: sequencer of the trial division prime test and its output register
// drives datapath commands from its status, holds the result item until taken
// depends on tdpt_pkg
module tdpt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_prime_flag,
    output tdpt_pkg::t_dp_cmd    o_cmd,
    input  tdpt_pkg::t_dp_status i_status
);
    import tdpt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_DIV   = 5'b00100,
        S_EVAL  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_result, n_result;
    logic   r_out_valid, n_out_valid;
    logic   r_out_prime, n_out_prime;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state, commands and output register load
    always_comb begin
        n_state     = r_state;
        n_result    = r_result;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_prime = r_out_prime;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.below_two) begin
                    n_result = 1'b0;
                    n_state  = S_DONE;
                end else if (i_status.is_two || i_status.sq_over) begin
                    n_result = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.rem_zero) begin
                    n_result = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.next_divisor = 1'b1;
                    n_state            = S_CHECK;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_result    <= n_result;
        r_out_prime <= n_out_prime;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_prime_flag = r_out_prime;

endmodule

@@ sv/trial_division_prime_test_unit.sv @@
// trial_division_prime_test_unit: one item in, one prime flag result item out.
// values below 3 and values that 4 exceeds are decided without a division; otherwise
// one serial division per trial divisor, up to about 46341 divisors at 32 bits,
// in the one-bit-per-cycle remainder unit; one item at a time.
// the next item is taken while a finished result still waits in the output register.
// reset (synchronous, active low) returns the sequencer to idle and empties the output.
module trial_division_prime_test_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tdpt_pkg::NUMBER_WIDTH-1:0] i_number_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_prime_flag
);
    import tdpt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer
    tdpt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_prime_flag (o_prime_flag),
        .o_cmd        (w_cmd),
        .i_status     (w_status)
    );

    // arithmetic
    tdpt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_number_value (i_number_value),
        .i_cmd          (w_cmd),
        .o_status       (w_status)
    );

endmodule

@@ sv/tdpt_checker.sv @@
// tdpt_checker: port-level assertions for trial_division_prime_test_unit
// attached to the top level by the bind statement at the end of this file
// no dependencies
module tdpt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_prime_flag
);

    // an accepted item keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    // a new result item only appears at the end of a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result item appeared without work in progress");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_prime_flag)))
        else $error("stalled result item changed");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result item valid right after reset");

endmodule

bind trial_division_prime_test_unit tdpt_checker u_tdpt_checker (.*);

@@ tb/sv/trial_division_prime_test_unit_tb.sv @@
// testbench of trial_division_prime_test_unit: values in, one primality flag item out each
// predicts every flag by its own trial division and checks the flags in order
// depends on tdpt_pkg and trial_division_prime_test_unit
module trial_division_prime_test_unit_tb;

    localparam int VALUE_WIDTH = 32;
    // well past the largest prime's divisor loop plus the random part with stalls
    localparam int RUN_LIMIT = 200_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 100;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [tdpt_pkg::NUMBER_WIDTH-1:0] i_number_value = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic                              o_prime_flag;

    // values waiting to be sent and flags waiting to come back
    logic [tdpt_pkg::NUMBER_WIDTH-1:0] pending_numbers[$];
    logic                              expected_flags[$];

    int mismatch_count = 0;
    int send_gap = 0;
    int sent_count = 0;
    int stall_left = 0;

    trial_division_prime_test_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_number_value(i_number_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_prime_flag  (o_prime_flag)
    );

    // clock, period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // primality of the low VALUE_WIDTH bits taken as a signed value
    function automatic logic prime_by_trial_division(input logic [31:0] raw);
        logic [63:0] sign_bit;
        logic [63:0] mask;
        logic [63:0] n;
        logic [63:0] d;
        sign_bit = 64'd1 << (VALUE_WIDTH - 1);
        mask = sign_bit | (sign_bit - 64'd1);
        n = {32'd0, raw} & mask;
        if ((n & sign_bit) != 64'd0) return 1'b0;
        if (n < 64'd2) return 1'b0;
        if (n == 64'd2) return 1'b1;
        for (d = 64'd2; d <= n / d; d++) begin
            if (n % d == 64'd0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random value: mostly small, some mid-size, negative ones, and large positive ones only with a small factor
    function automatic logic [31:0] pick_number();
        int roll;
        logic [31:0] raw;
        roll = $urandom_range(0, 99);
        raw = $urandom;
        if (roll < 45) return $urandom_range(0, 65535);
        if (roll < 55) return $urandom_range(0, 1 << 20);
        if (roll < 65) return $urandom_range(0, 40);
        if (roll < 77) return {1'b1, raw[30:0]};
        if (roll < 88) return {1'b0, raw[30:1], 1'b0};
        return $urandom_range(1, 715827882) * 3;
    endfunction

    // driver: sends the pending values, predicts each flag as its item is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                expected_flags.push_back(prime_by_trial_division(i_number_value));
                sent_count <= sent_count + 1;
            end
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_numbers.size() > 0) begin
                i_in_valid <= 1'b1;
                i_number_value <= pending_numbers.pop_front();
                // every few dozen items a stretch without gaps
                send_gap <= ((sent_count % 32) < 8) ? 0 : pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result stall: runs of random length, with calm stretches between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 99) < 30) begin
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                           : $urandom_range(1, 3);
            end
        end
    end

    // monitor: each taken flag against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_flags.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result item: prime_flag=%0b", o_prime_flag);
                mismatch_count <= mismatch_count + 1;
            end else if (expected_flags[0] !== o_prime_flag) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("prime flag mismatch: expected %0b, got %0b",
                             expected_flags[0], o_prime_flag);
                mismatch_count <= mismatch_count + 1;
                void'(expected_flags.pop_front());
            end else begin
                void'(expected_flags.pop_front());
            end
        end
    end

    // stimulus and end of run
    initial begin
        // field extremes and the special values
        pending_numbers.push_back(32'd0);
        pending_numbers.push_back(32'd1);
        pending_numbers.push_back(32'd2);
        pending_numbers.push_back(32'd3);
        pending_numbers.push_back(32'd4);
        pending_numbers.push_back(32'd5);
        pending_numbers.push_back(32'd6);
        pending_numbers.push_back(32'd8);
        pending_numbers.push_back(32'd9);
        pending_numbers.push_back(32'd25);
        pending_numbers.push_back(32'd49);
        pending_numbers.push_back(32'd121);
        pending_numbers.push_back(32'hFFFF_FFFF);
        pending_numbers.push_back(32'h8000_0000);
        pending_numbers.push_back(32'hFFFF_FFFE);
        pending_numbers.push_back(32'd65521);
        pending_numbers.push_back(32'd65537);
        pending_numbers.push_back(32'd1000003);
        pending_numbers.push_back(32'd2147395600);
        pending_numbers.push_back(32'h7FFF_FFFE);
        pending_numbers.push_back(32'h7FFF_FFFF);
        repeat (RANDOM_ITEMS) pending_numbers.push_back(pick_number());

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all items taken, then all flags back, then a short drain
        while (pending_numbers.size() > 0 || i_in_valid) @(posedge i_clk);
        while (expected_flags.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (mismatch_count == 0 && expected_flags.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #RUN_LIMIT;
        $display("Test completed with failures");
        $finish;
    end

endmodule
